>>> sv/motor_fault_persistence_monitor_macros.svh
// Assertion macros for the motor fault persistence monitor.
// Expects clk and arst_n in the scope of each use.
`ifndef MOTOR_FAULT_PERSISTENCE_MONITOR_MACROS_SVH
`define MOTOR_FAULT_PERSISTENCE_MONITOR_MACROS_SVH

`ifndef SYNTH
`define FMP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fmp assertion failed");
`define FMP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fmp assertion failed");
`else
`define FMP_ASSERT_IMP(label, ante, cons)
`define FMP_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> sv/fmp_pkg.sv
// Shared types and constants of the motor fault persistence monitor.
// No dependencies.
`timescale 1ns / 1ps

package fmp_pkg;

	typedef logic [6:0]  persist_t;
	typedef logic [16:0] comm_cnt_t;

	localparam persist_t  PERSIST_MAX = 7'd127;
	localparam comm_cnt_t COMM_MAX    = 17'd131071;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_CURRENT = 2'd1,
		ERR_COMM    = 2'd2,
		ERR_TEMP    = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		REG_CURRENT_LIMIT  = 3'd0,
		REG_REVERSE_CUTOFF = 3'd1,
		REG_TEMP_LIMIT     = 3'd2,
		REG_PERSIST_COUNT  = 3'd3,
		REG_COMM_TIMEOUT   = 3'd4
	} reg_idx_t;

	localparam logic [14:0]        RST_CURRENT_LIMIT  = 15'd6400;
	localparam logic signed [15:0] RST_REVERSE_CUTOFF = -16'sd2560;
	localparam logic signed [15:0] RST_TEMP_LIMIT     = 16'sd20480;
	localparam persist_t           RST_PERSIST_COUNT  = 7'd60;
	localparam comm_cnt_t          RST_COMM_TIMEOUT   = 17'd100000;

	typedef struct packed {
		logic [14:0]        current_limit;
		logic signed [15:0] reverse_current_cutoff;
		logic signed [15:0] temperature_limit;
		persist_t           persist_count;
		comm_cnt_t          comm_timeout_count;
	} cfg_t;

	// counters of the selected motor
	typedef struct packed {
		logic      motor_ok;
		persist_t  cur;
		comm_cnt_t comm;
		persist_t  temp;
	} ctr_rd_t;

	typedef struct packed {
		logic      cur_we;
		logic      comm_we;
		logic      temp_we;
		persist_t  cur;
		comm_cnt_t comm;
		persist_t  temp;
	} ctr_wr_t;

endpackage

>>> sv/fmp_req_if.sv
// Input channel of the fault monitor: one fault check item.
// Depends on nothing.
`timescale 1ns / 1ps

interface fmp_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         motor_index;
	logic signed [15:0] current_sample;
	logic signed [15:0] temperature_sample;
	logic               heartbeat_arrived;
	logic signed [31:0] position_sample;

	modport source (output valid, motor_index, current_sample, temperature_sample,
		heartbeat_arrived, position_sample, input ready);
	modport sink (input valid, motor_index, current_sample, temperature_sample,
		heartbeat_arrived, position_sample, output ready);
endinterface

>>> sv/fmp_rsp_if.sv
// Output channel of the fault monitor: one result item per check.
// Depends on nothing.
`timescale 1ns / 1ps

interface fmp_rsp_if;
	logic               valid;
	logic               ready;
	logic               fault;
	logic [1:0]         error_kind;
	logic               safe_cmd_valid;
	logic signed [31:0] safe_target_pos;

	modport source (output valid, fault, error_kind, safe_cmd_valid, safe_target_pos,
		input ready);
	modport sink (input valid, fault, error_kind, safe_cmd_valid, safe_target_pos,
		output ready);
endinterface

>>> sv/fmp_cfg_regs.sv
// Configuration register file of the fault monitor.
// Depends on fmp_pkg.
`timescale 1ns / 1ps

module fmp_cfg_regs
	import fmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [16:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_limit          <= RST_CURRENT_LIMIT;
			cfg_q.reverse_current_cutoff <= RST_REVERSE_CUTOFF;
			cfg_q.temperature_limit      <= RST_TEMP_LIMIT;
			cfg_q.persist_count          <= RST_PERSIST_COUNT;
			cfg_q.comm_timeout_count     <= RST_COMM_TIMEOUT;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CURRENT_LIMIT:  cfg_q.current_limit <= wr_data[14:0];
				REG_REVERSE_CUTOFF: cfg_q.reverse_current_cutoff <= signed'(wr_data[15:0]);
				REG_TEMP_LIMIT:     cfg_q.temperature_limit <= signed'(wr_data[15:0]);
				REG_PERSIST_COUNT:  cfg_q.persist_count <= wr_data[6:0];
				REG_COMM_TIMEOUT:   cfg_q.comm_timeout_count <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/fmp_ctr_bank.sv
// Per-motor persistence counters, one lane of flops per motor.
// Depends on fmp_pkg.
`timescale 1ns / 1ps

module fmp_ctr_bank
	import fmp_pkg::*;
#(
	parameter int MOTOR_COUNT = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] motor_index,
	input  logic       upd,
	input  ctr_wr_t    wr,
	output ctr_rd_t    rd
);

	persist_t  cur_q  [MOTOR_COUNT];
	comm_cnt_t comm_q [MOTOR_COUNT];
	persist_t  temp_q [MOTOR_COUNT];
	logic [MOTOR_COUNT-1:0] hit;

	always_comb begin
		for (int m = 0; m < MOTOR_COUNT; m++) begin
			hit[m] = ({29'd0, motor_index} == 32'(m));
		end
	end

	// lanes are one-hot, so an OR of the masked lanes selects
	always_comb begin
		rd          = '0;
		rd.motor_ok = |hit;
		for (int m = 0; m < MOTOR_COUNT; m++) begin
			if (hit[m]) begin
				rd.cur  = rd.cur | cur_q[m];
				rd.comm = rd.comm | comm_q[m];
				rd.temp = rd.temp | temp_q[m];
			end
		end
	end

	for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_lane
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cur_q[g]  <= '0;
				comm_q[g] <= '0;
				temp_q[g] <= '0;
			end else if (upd && hit[g]) begin
				if (wr.cur_we) begin
					cur_q[g] <= wr.cur;
				end
				if (wr.comm_we) begin
					comm_q[g] <= wr.comm;
				end
				if (wr.temp_we) begin
					temp_q[g] <= wr.temp;
				end
			end
		end
	end

endmodule

>>> sv/fmp_check.sv
// Check logic: over-current, communication timeout, over-temperature in order.
// Depends on fmp_pkg.
`timescale 1ns / 1ps

module fmp_check
	import fmp_pkg::*;
(
	input  cfg_t               cfg,
	input  ctr_rd_t            rd,
	input  logic signed [15:0] current_sample,
	input  logic signed [15:0] temperature_sample,
	input  logic               heartbeat_arrived,
	output ctr_wr_t            wr,
	output logic               fired,
	output err_t               fire_kind
);

	logic [15:0] mag;
	logic        cur_in_range;
	logic        cur_fire;
	logic        comm_fire;
	logic        temp_fire;

	always_comb begin
		// magnitude of the most negative sample is 32768, which fits unsigned
		mag          = current_sample[15] ? 16'(~current_sample + 16'd1) : current_sample;
		cur_in_range = (current_sample >= cfg.reverse_current_cutoff);

		if (mag > {1'b0, cfg.current_limit}) begin
			wr.cur = (rd.cur == PERSIST_MAX) ? PERSIST_MAX : 7'(rd.cur + 7'd1);
		end else begin
			wr.cur = '0;
		end
		cur_fire = rd.motor_ok && cur_in_range && (wr.cur > cfg.persist_count);

		if (heartbeat_arrived) begin
			wr.comm = '0;
		end else begin
			wr.comm = (rd.comm == COMM_MAX) ? COMM_MAX : 17'(rd.comm + 17'd1);
		end
		comm_fire = rd.motor_ok && !cur_fire && (wr.comm > cfg.comm_timeout_count);

		if (temperature_sample > cfg.temperature_limit) begin
			wr.temp = (rd.temp == PERSIST_MAX) ? PERSIST_MAX : 7'(rd.temp + 7'd1);
		end else begin
			wr.temp = '0;
		end
		temp_fire = rd.motor_ok && !cur_fire && !comm_fire &&
			(wr.temp > cfg.persist_count);

		// a fired check stops the later ones, their counters hold
		wr.cur_we  = rd.motor_ok && cur_in_range;
		wr.comm_we = rd.motor_ok && !cur_fire;
		wr.temp_we = rd.motor_ok && !cur_fire && !comm_fire;

		fired = cur_fire || comm_fire || temp_fire;
		priority if (cur_fire) begin
			fire_kind = ERR_CURRENT;
		end else if (comm_fire) begin
			fire_kind = ERR_COMM;
		end else if (temp_fire) begin
			fire_kind = ERR_TEMP;
		end else begin
			fire_kind = ERR_NONE;
		end
	end

endmodule

>>> sv/motor_fault_persistence_monitor.sv
// Motor fault persistence monitor. Each request item is one fault check for one
// motor; every item yields exactly one result item. An item is taken into an
// input register, checked there against the selected motor's counters and the
// configuration, and its result lands in an output register, so the block takes
// one item per cycle. A result is offered from the output register once its
// item has moved on from the input register. Throughput drops only while the
// output register is full and not taken. The error kind latches and is cleared
// only by reset. Configuration is written through wr_en, wr_index and wr_data;
// the user must do so only while no item is in flight; the block does not check.
`timescale 1ns / 1ps

`include "motor_fault_persistence_monitor_macros.svh"

module motor_fault_persistence_monitor
	import fmp_pkg::*;
#(
	parameter int MOTOR_COUNT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [16:0] wr_data,
	fmp_req_if.sink     req,
	fmp_rsp_if.source   rsp
);

	cfg_t    cfg;
	ctr_rd_t rd;
	ctr_wr_t wr;
	logic    fired;
	err_t    fire_kind;

	logic               valid_s1;
	logic [2:0]         motor_index_s1;
	logic signed [15:0] current_sample_s1;
	logic signed [15:0] temperature_sample_s1;
	logic               heartbeat_arrived_s1;
	logic signed [31:0] position_sample_s1;

	logic               valid_s2;
	logic               fault_s2;
	err_t               error_kind_s2;
	logic signed [31:0] safe_target_pos_s2;

	err_t latched_q;
	err_t latched_next;
	logic adv;

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || !valid_s2 || rsp.ready;

	fmp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	fmp_ctr_bank #(
		.MOTOR_COUNT (MOTOR_COUNT)
	) u_ctr (
		.clk         (clk),
		.arst_n      (arst_n),
		.motor_index (motor_index_s1),
		.upd         (adv),
		.wr          (wr),
		.rd          (rd)
	);

	fmp_check u_check (
		.cfg                (cfg),
		.rd                 (rd),
		.current_sample     (current_sample_s1),
		.temperature_sample (temperature_sample_s1),
		.heartbeat_arrived  (heartbeat_arrived_s1),
		.wr                 (wr),
		.fired              (fired),
		.fire_kind          (fire_kind)
	);

	assign latched_next = fired ? fire_kind : latched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			motor_index_s1        <= req.motor_index;
			current_sample_s1     <= req.current_sample;
			temperature_sample_s1 <= req.temperature_sample;
			heartbeat_arrived_s1  <= req.heartbeat_arrived;
			position_sample_s1    <= req.position_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			latched_q <= ERR_NONE;
		end else begin
			if (adv) begin
				valid_s2  <= 1'b1;
				latched_q <= latched_next;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fault_s2           <= fired;
			error_kind_s2      <= latched_next;
			safe_target_pos_s2 <= (latched_next == ERR_COMM) ? position_sample_s1 : '0;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.fault           = fault_s2;
	assign rsp.error_kind      = error_kind_s2;
	assign rsp.safe_cmd_valid  = (error_kind_s2 != ERR_NONE);
	assign rsp.safe_target_pos = safe_target_pos_s2;

	`FMP_ASSERT_NXT(a_latch_sticky, latched_q != ERR_NONE, latched_q != ERR_NONE)
	`FMP_ASSERT_NXT(a_latch_hold, !adv, $stable(latched_q))
	`FMP_ASSERT_IMP(a_fault_kind, rsp.valid && rsp.fault, rsp.error_kind != ERR_NONE)
	`FMP_ASSERT_IMP(a_pos_zero, rsp.valid && rsp.error_kind != ERR_COMM, rsp.safe_target_pos == '0)
	`FMP_ASSERT_IMP(a_no_fire_bad_motor, valid_s1 && !rd.motor_ok, !fired)

endmodule

>>> test/motor_fault_persistence_monitor_checker.sv
// Checker for the motor fault persistence monitor: watches both channels and the
// configuration port, predicts each result item and compares it field by field.
// Depends on fmp_pkg, fmp_req_if and fmp_rsp_if.
`timescale 1ns / 1ps

module motor_fault_persistence_monitor_checker
	import fmp_pkg::*;
#(
	parameter int MOTOR_COUNT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [16:0] wr_data,
	input  logic        run_done,
	fmp_req_if          req,
	fmp_rsp_if          rsp,
	output int          results_due,
	output int          fail_count
);

	typedef struct packed {
		logic               fault;
		err_t               error_kind;
		logic               safe_cmd_valid;
		logic signed [31:0] safe_target_pos;
	} verdict_t;

	cfg_t      cfg;
	persist_t  ctr_current [MOTOR_COUNT];
	comm_cnt_t ctr_missed [MOTOR_COUNT];
	persist_t  ctr_temp [MOTOR_COUNT];
	err_t      latched_kind;
	verdict_t  verdicts_due [$];

	task automatic report(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	// Append one predicted result item at the tail of the queue.
	task automatic queue_verdict(input verdict_t v);
		verdicts_due = {verdicts_due, v};
	endtask

	function automatic persist_t persist_step(input persist_t c);
		return (c < PERSIST_MAX) ? c + 7'd1 : c;
	endfunction

	// Run the three checks in order on one motor's counters; the first to fire
	// stops the later ones.
	function automatic verdict_t run_fault_checks(input logic [2:0] motor,
			input logic signed [15:0] cur, input logic signed [15:0] temp,
			input logic beat, input logic signed [31:0] pos);
		verdict_t v;
		int       mag;
		logic     fired;
		fired = 1'b0;
		if (motor < MOTOR_COUNT) begin
			if (cur >= $signed(cfg.reverse_current_cutoff)) begin
				mag = (cur < 0) ? -int'(cur) : int'(cur);
				if (mag > int'(cfg.current_limit))
					ctr_current[motor] = persist_step(ctr_current[motor]);
				else
					ctr_current[motor] = '0;
				if (ctr_current[motor] > cfg.persist_count) begin
					latched_kind = ERR_CURRENT;
					fired = 1'b1;
				end
			end
			if (!fired) begin
				if (beat)
					ctr_missed[motor] = '0;
				else if (ctr_missed[motor] < COMM_MAX)
					ctr_missed[motor] = ctr_missed[motor] + 17'd1;
				if (ctr_missed[motor] > cfg.comm_timeout_count) begin
					latched_kind = ERR_COMM;
					fired = 1'b1;
				end
			end
			if (!fired) begin
				if (temp > $signed(cfg.temperature_limit))
					ctr_temp[motor] = persist_step(ctr_temp[motor]);
				else
					ctr_temp[motor] = '0;
				if (ctr_temp[motor] > cfg.persist_count) begin
					latched_kind = ERR_TEMP;
					fired = 1'b1;
				end
			end
		end
		v.fault = fired;
		v.error_kind = latched_kind;
		v.safe_cmd_valid = (latched_kind != ERR_NONE);
		v.safe_target_pos = (latched_kind == ERR_COMM) ? pos : '0;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		verdict_t want;
		if (!arst_n) begin
			cfg.current_limit = RST_CURRENT_LIMIT;
			cfg.reverse_current_cutoff = RST_REVERSE_CUTOFF;
			cfg.temperature_limit = RST_TEMP_LIMIT;
			cfg.persist_count = RST_PERSIST_COUNT;
			cfg.comm_timeout_count = RST_COMM_TIMEOUT;
			for (int m = 0; m < MOTOR_COUNT; m++) begin
				ctr_current[m] = '0;
				ctr_missed[m] = '0;
				ctr_temp[m] = '0;
			end
			latched_kind = ERR_NONE;
			verdicts_due.delete();
		end else begin
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_CURRENT_LIMIT:  cfg.current_limit = wr_data[14:0];
					REG_REVERSE_CUTOFF: cfg.reverse_current_cutoff = wr_data[15:0];
					REG_TEMP_LIMIT:     cfg.temperature_limit = wr_data[15:0];
					REG_PERSIST_COUNT:  cfg.persist_count = wr_data[6:0];
					REG_COMM_TIMEOUT:   cfg.comm_timeout_count = wr_data[16:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				queue_verdict(run_fault_checks(req.motor_index, req.current_sample,
					req.temperature_sample, req.heartbeat_arrived, req.position_sample));
			if (rsp.valid && rsp.ready) begin
				if (verdicts_due.size() == 0) begin
					report("result item with no check outstanding");
				end else begin
					want = verdicts_due.pop_front();
					if (rsp.fault !== want.fault)
						report($sformatf("fault %b, want %b", rsp.fault, want.fault));
					if (rsp.error_kind !== want.error_kind)
						report($sformatf("error_kind %0d, want %0d", rsp.error_kind,
							want.error_kind));
					if (rsp.safe_cmd_valid !== want.safe_cmd_valid)
						report($sformatf("safe_cmd_valid %b, want %b", rsp.safe_cmd_valid,
							want.safe_cmd_valid));
					if (rsp.safe_target_pos !== want.safe_target_pos)
						report($sformatf("safe_target_pos %h, want %h", rsp.safe_target_pos,
							want.safe_target_pos));
				end
			end
		end
		results_due = verdicts_due.size();
	end

	always @(posedge run_done) begin
		if (verdicts_due.size() != 0)
			report($sformatf("%0d result items never arrived", verdicts_due.size()));
	end

endmodule

>>> test/motor_fault_persistence_monitor_test.sv
// Top of the motor fault persistence monitor test: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on fmp_pkg, both channel interfaces,
// the block and motor_fault_persistence_monitor_checker.
`timescale 1ns / 1ps

module motor_fault_persistence_monitor_test
	import fmp_pkg::*;
();

	localparam int MOTOR_COUNT     = 6;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int RANDOM_PHASES   = 10;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int HOLD_OFF_CYCLES = 150;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [16:0] wr_data;
	logic        run_done;
	int          results_due;
	int          fail_count;
	int          cycle_count;
	cfg_t        cfg_now;
	bit          sender_steady = 1'b0;
	bit          receiver_steady = 1'b0;
	bit          pressure_go = 1'b0;

	fmp_req_if req ();
	fmp_rsp_if rsp ();

	motor_fault_persistence_monitor #(.MOTOR_COUNT(MOTOR_COUNT)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req),
		.rsp      (rsp)
	);

	motor_fault_persistence_monitor_checker #(.MOTOR_COUNT(MOTOR_COUNT)) fault_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.run_done    (run_done),
		.req         (req),
		.rsp         (rsp),
		.results_due (results_due),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("motor_fault_persistence_monitor_test NOT OK");
		$finish;
	end

	// Receiver: random stalls, one long hold-off once pressure is asked for.
	initial begin : receiver
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_go && !held) begin
				held = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= receiver_steady || ($urandom_range(99) >= 28);
			end
		end
	end

	task automatic offer_check(input logic [2:0] motor, input logic signed [15:0] cur,
			input logic signed [15:0] temp, input logic beat, input logic signed [31:0] pos);
		if (!sender_steady && $urandom_range(99) < 20) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.motor_index <= motor;
		req.current_sample <= cur;
		req.temperature_sample <= temp;
		req.heartbeat_arrived <= beat;
		req.position_sample <= pos;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// Hold until every expected result is back, then let the pipeline settle.
	task automatic wait_idle();
		@(negedge clk);
		while (results_due != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [16:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
	endtask

	// Unused upper data bits get random values; the block must drop them.
	task automatic set_config(input int cur_lim, input int cutoff, input int temp_lim,
			input int persist, input int comm);
		write_reg(REG_CURRENT_LIMIT, {2'($urandom), 15'(cur_lim)});
		write_reg(REG_REVERSE_CUTOFF, {1'($urandom), 16'(cutoff)});
		write_reg(REG_TEMP_LIMIT, {1'($urandom), 16'(temp_lim)});
		write_reg(REG_PERSIST_COUNT, {10'($urandom), 7'(persist)});
		write_reg(REG_COMM_TIMEOUT, 17'(comm));
		wr_en <= 1'b0;
		cfg_now.current_limit = 15'(cur_lim);
		cfg_now.reverse_current_cutoff = 16'(cutoff);
		cfg_now.temperature_limit = 16'(temp_lim);
		cfg_now.persist_count = 7'(persist);
		cfg_now.comm_timeout_count = 17'(comm);
	endtask

	function automatic logic signed [15:0] pick_current(input bit over);
		int lim;
		lim = int'(cfg_now.current_limit);
		if (over) begin
			if (lim == 32767)
				return 16'sh8000;
			if ($urandom_range(1))
				return 16'(lim + 1 + int'($urandom_range(32766 - lim)));
			return 16'(-(lim + 1 + int'($urandom_range(32767 - lim))));
		end
		return 16'(int'($urandom_range(2 * lim)) - lim);
	endfunction

	function automatic logic signed [15:0] pick_temp(input bit over);
		int lim;
		lim = int'($signed(cfg_now.temperature_limit));
		if (over && lim < 32767)
			return 16'(lim + 1 + int'($urandom_range(32766 - lim)));
		return 16'(lim - int'($urandom_range(lim + 32768)));
	endfunction

	// Bursts on one motor with a steady over-limit pattern drive the counters up
	// to their limits; a few items are plain noise.
	task automatic random_phase(input int items);
		int         sent;
		int         reach;
		int         len;
		logic [2:0] motor;
		bit         over_cur;
		bit         miss;
		bit         over_temp;
		bit         clean;
		bit         flip;
		sent = 0;
		while (sent < items) begin
			reach = int'(cfg_now.persist_count);
			if (int'(cfg_now.comm_timeout_count) > reach)
				reach = int'(cfg_now.comm_timeout_count);
			if (reach > 130)
				reach = 130;
			clean = (reach >= 126) || $urandom_range(1);
			len = (reach >= 126 && $urandom_range(1)) ? reach + 3 :
				int'($urandom_range(reach + 3, 1));
			motor = ($urandom_range(99) < 6) ? 3'($urandom_range(7)) :
				3'($urandom_range(MOTOR_COUNT - 1));
			over_cur = 1'($urandom_range(1));
			miss = 1'($urandom_range(1));
			over_temp = 1'($urandom_range(1));
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(99) < 5) begin
					offer_check(3'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
						32'($urandom));
				end else begin
					flip = !clean && ($urandom_range(99) < 15);
					offer_check(motor, pick_current(over_cur ^ flip),
						pick_temp(over_temp ^ (flip && $urandom_range(1))),
						!(miss ^ (flip && $urandom_range(1))), 32'($urandom));
				end
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_CURRENT_LIMIT;
		wr_data <= '0;
		run_done <= 1'b0;
		req.valid <= 1'b0;
		req.motor_index <= '0;
		req.current_sample <= '0;
		req.temperature_sample <= '0;
		req.heartbeat_arrived <= 1'b0;
		req.position_sample <= '0;
		cfg_now = '{RST_CURRENT_LIMIT, RST_REVERSE_CUTOFF, RST_TEMP_LIMIT,
			RST_PERSIST_COUNT, RST_COMM_TIMEOUT};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: most negative current falls below the cutoff
		offer_check(3'd0, 16'sh8000, 16'sh7fff, 1'b1, 32'sh7fffffff);
		offer_check(3'd0, 16'sh7fff, 16'sh8000, 1'b0, 32'sh80000000);
		offer_check(3'd6, 16'sh7fff, 16'sh7fff, 1'b0, 32'sh7fffffff);
		req.valid <= 1'b0;
		wait_idle();

		set_config(100, -32768, 0, 1, 2);
		// most negative current counts as magnitude 32768
		offer_check(3'd1, 16'sh8000, -16'sd1, 1'b1, 32'sh0000ffff);
		offer_check(3'd1, 16'sh8000, -16'sd1, 1'b1, 32'sh12345678);
		// current exactly at the limit clears its counter
		offer_check(3'd0, -16'sd100, -16'sd1, 1'b1, 32'sh7fffffff);
		offer_check(3'd2, 16'sd0, 16'sh8000, 1'b0, 32'sh7fffffff);
		offer_check(3'd2, 16'sd0, 16'sh8000, 1'b0, 32'sh7fffffff);
		// communication fault overwrites the latched current error
		offer_check(3'd2, 16'sd0, 16'sh8000, 1'b0, 32'sh80000000);
		offer_check(3'd7, 16'sh7fff, 16'sh7fff, 1'b0, 32'shffffffff);
		offer_check(3'd3, 16'sd0, 16'sh7fff, 1'b1, 32'sh55aa55aa);
		offer_check(3'd3, 16'sd0, 16'sh7fff, 1'b1, 32'shaa55aa55);
		// over current fires first and leaves the other counters alone
		offer_check(3'd4, 16'sh7fff, 16'sh7fff, 1'b0, 32'sh0);
		offer_check(3'd4, 16'sh7fff, 16'sh7fff, 1'b0, 32'sh0);
		offer_check(3'd5, 16'sd101, 16'sd1, 1'b1, -32'sd1);
		offer_check(3'd6, 16'sd0, 16'sd0, 1'b1, 32'sh7fffffff);
		req.valid <= 1'b0;

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: set_config(0, 0, -32768, 0, 0);
				1: set_config(32767, -32768, 32767, 126, 131070);
				// counters at full scale can never exceed these limits
				2: set_config(200, -32768, 0, 127, 131071);
				default: set_config($urandom_range(1) ? int'($urandom_range(32767)) :
					int'($urandom_range(2000)), -int'($urandom_range(32768)),
					int'($signed(16'($urandom))), int'($urandom_range(6)),
					int'($urandom_range(6)));
			endcase
			sender_steady = (p == 5);
			receiver_steady <= (p == 7);
			if (p == 3)
				pressure_go <= 1'b1;
			random_phase(ITEMS_PER_PHASE);
			req.valid <= 1'b0;
		end
		sender_steady = 1'b0;
		receiver_steady <= 1'b0;

		@(negedge clk);
		for (int k = 0; k < 2000 && results_due != 0; k++) @(negedge clk);
		repeat (8) @(posedge clk);
		run_done <= 1'b1;
		@(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("motor_fault_persistence_monitor_test OK");
		else
			$display("motor_fault_persistence_monitor_test NOT OK");
		$finish;
	end

endmodule

>>> motor_fault_persistence_monitor.f
+incdir+sv
sv/fmp_pkg.sv
sv/fmp_req_if.sv
sv/fmp_rsp_if.sv
sv/fmp_cfg_regs.sv
sv/fmp_ctr_bank.sv
sv/fmp_check.sv
sv/motor_fault_persistence_monitor.sv
test/motor_fault_persistence_monitor_checker.sv
test/motor_fault_persistence_monitor_test.sv
